// ----- rtl/geh_pkg.sv -----
package geh_pkg;

  // Sizing
  localparam int MAX_BINS      = 256;
  localparam int NUM_DETECTORS = 64;

  // Field widths (fixed by the interface)
  localparam int KIND_W     = 2;
  localparam int FTIME_W    = 40;
  localparam int DET_W      = 6;
  localparam int TIME_W     = 24;
  localparam int EIDX_W     = 9;
  localparam int BIDX_W     = 8;
  localparam int NB_CFG_W   = 9;
  localparam int CNT_W      = 32;
  localparam int RES_KIND_W = 1;

  // Input word layout, lowest bit first
  localparam int FTIME_LSB = 0;
  localparam int DET_LSB   = FTIME_LSB + FTIME_W;
  localparam int TOF_LSB   = DET_LSB + DET_W;
  localparam int EIDX_LSB  = TOF_LSB + TIME_W;
  localparam int EVAL_LSB  = EIDX_LSB + EIDX_W;
  localparam int BIDX_LSB  = EVAL_LSB + TIME_W;
  localparam int IN_RAW_W  = BIDX_LSB + BIDX_W;
  localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;

  // Output word layout, lowest bit first
  localparam int FIW_LSB    = 0;
  localparam int FRAMES_LSB = FIW_LSB + 1;
  localparam int COUNT_LSB  = FRAMES_LSB + CNT_W;
  localparam int OUT_RAW_W  = COUNT_LSB + CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FTIME_W;

  // Derived storage sizes
  localparam int BIN_W      = $clog2(MAX_BINS + 1);
  localparam int EDGE_DEPTH = MAX_BINS + 1;
  localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
  localparam int CNT_DEPTH  = NUM_DETECTORS * MAX_BINS;
  localparam int CNT_AW     = $clog2(CNT_DEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_EDGE  = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [RES_KIND_W-1:0] {
    RES_FRAME = 1'b0,
    RES_COUNT = 1'b1
  } res_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_START = 2'd0,
    CFG_WIN_END   = 2'd1,
    CFG_NUM_BINS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMP_WIN_START,
    CMP_WIN_END,
    CMP_EDGE
  } cmp_sel_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FR_LO,
    S_FR_HI,
    S_EDGE_LO,
    S_EDGE_HI,
    S_SEARCH,
    S_CNT_WR,
    S_READ,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] frames;
    logic             fiw;
  } out_word_t;

endpackage

// ----- rtl/geh_ram.sv -----
module geh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/geh_cmp.sv -----
module geh_cmp import geh_pkg::*; (
  input  cmp_sel_e           sel_i,
  input  logic [FTIME_W-1:0] ftime_i,
  input  logic [FTIME_W-1:0] win_start_i,
  input  logic [FTIME_W-1:0] win_end_i,
  input  logic [TIME_W-1:0]  tof_i,
  input  logic [TIME_W-1:0]  edge_i,
  output logic               lt_o
);

  logic [FTIME_W-1:0] op_a;
  logic [FTIME_W-1:0] op_b;

  // single shared less-than, operands picked by the sequencer
  always_comb begin
    op_a = ftime_i;
    op_b = win_start_i;
    unique case (sel_i)
      CMP_WIN_START: begin
        op_a = ftime_i;
        op_b = win_start_i;
      end
      CMP_WIN_END: begin
        op_a = ftime_i;
        op_b = win_end_i;
      end
      CMP_EDGE: begin
        op_a = FTIME_W'(tof_i);
        op_b = FTIME_W'(edge_i);
      end
      default: begin
        op_a = ftime_i;
        op_b = win_start_i;
      end
    endcase
  end

  assign lt_o = (op_a < op_b);

endmodule

// ----- rtl/gated_event_histogrammer.sv -----
// Gated time-of-flight histogrammer.
// Input stream (s_axis): one word per command, tuser = kind (frame header,
// event, edge write, count read), tdata = packed command fields.
// Output stream (m_axis): frame reports and count-read answers, tuser tells
// which. Events and edge writes produce no output word.
// Config channel (cfg_*): window start/end and bins in use; always ready,
// write only while no command is in flight.
// Steps per word: edge write is done on accept; frame header runs the window
// start and end checks, then the output hand-off; count read fetches the
// count, then the hand-off; event runs the edge checks, one binary-search step
// per cycle through the shared comparator and the registered edge RAM read,
// then a read-modify-write of the count RAM. 256 bins take an 8-step search.
// Reset: a clearing pass over all NUM_DETECTORS * MAX_BINS (16384) entries
// zeroes the count RAM; s_axis_tready stays low until it ends. Edge table is not
// cleared and must be written before use.
// Stall: results sit in an output register; the next command is accepted
// while it waits, and only a second result waits for the register to drain.
module gated_event_histogrammer import geh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // frame_time, detector_id, time_offset, edge_index, edge_value, bin_index
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [KIND_W-1:0]     s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // frame_in_window, frames_counted, bin_count
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // result_kind
  output logic [RES_KIND_W-1:0] m_axis_tuser,
  // config writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // detector row times bins per row plus bin
  function automatic logic [CNT_AW-1:0] cnt_addr(logic [DET_W-1:0] det,
                                                 logic [BIN_W-1:0] bin);
    return CNT_AW'(det) * CNT_AW'(MAX_BINS) + CNT_AW'(bin);
  endfunction

  // unpacked command fields
  logic [FTIME_W-1:0] in_ftime;
  logic [DET_W-1:0]   in_det;
  logic [TIME_W-1:0]  in_tof;
  logic [EIDX_W-1:0]  in_eidx;
  logic [TIME_W-1:0]  in_eval;
  logic [BIDX_W-1:0]  in_bidx;
  kind_e              in_kind;

  assign in_ftime = s_axis_tdata[FTIME_LSB +: FTIME_W];
  assign in_det   = s_axis_tdata[DET_LSB +: DET_W];
  assign in_tof   = s_axis_tdata[TOF_LSB +: TIME_W];
  assign in_eidx  = s_axis_tdata[EIDX_LSB +: EIDX_W];
  assign in_eval  = s_axis_tdata[EVAL_LSB +: TIME_W];
  assign in_bidx  = s_axis_tdata[BIDX_LSB +: BIDX_W];
  assign in_kind  = kind_e'(s_axis_tuser);

  // config registers
  logic [FTIME_W-1:0] win_start_q;
  logic [FTIME_W-1:0] win_end_q;
  logic [BIN_W-1:0]   nb_q;
  logic [NB_CFG_W-1:0] cfg_nb;

  // control state
  state_e             state_q, state_d;
  logic               fa_q, fa_d;
  logic [CNT_W-1:0]   frames_q, frames_d;
  logic [CNT_AW-1:0]  clr_q, clr_d;
  logic               ge_start_q, ge_start_d;
  logic               m_valid_q, m_valid_d;

  // per-command payload
  logic [DET_W-1:0]   det_q, det_d;
  logic [TIME_W-1:0]  tof_q, tof_d;
  logic [FTIME_W-1:0] ftime_q, ftime_d;
  logic               rd_ok_q, rd_ok_d;
  logic [BIN_W-1:0]   lo_q, lo_d;
  logic [BIN_W-1:0]   hi_q, hi_d;
  res_kind_e          res_kind_q, res_kind_d;
  out_word_t          res_q, res_d;
  res_kind_e          m_kind_q;
  out_word_t          m_word_q;
  logic               out_load;

  // search arithmetic
  logic [BIN_W:0]     sum_q;
  logic [BIN_W-1:0]   mid_q;
  logic [BIN_W:0]     sum_d;
  logic [BIN_W-1:0]   span_d;

  // memory ports
  logic               edge_we;
  logic [EDGE_AW-1:0] edge_raddr;
  logic [TIME_W-1:0]  edge_rdata;
  logic               cnt_we;
  logic [CNT_AW-1:0]  cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic [CNT_AW-1:0]  cnt_raddr;
  logic [CNT_W-1:0]   cnt_rdata;

  // shared comparator
  cmp_sel_e           cmp_sel;
  logic               cmp_lt;

  assign sum_q  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_q  = sum_q[BIN_W:1];
  assign sum_d  = {1'b0, lo_d} + {1'b0, hi_d};
  assign span_d = hi_d - lo_d;

  geh_cmp u_cmp (
    .sel_i       (cmp_sel),
    .ftime_i     (ftime_q),
    .win_start_i (win_start_q),
    .win_end_i   (win_end_q),
    .tof_i       (tof_q),
    .edge_i      (edge_rdata),
    .lt_o        (cmp_lt)
  );

  // bin edge table, written straight from an edge-write command
  geh_ram #(
    .WIDTH (TIME_W),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (EDGE_AW'(in_eidx)),
    .wdata_i (in_eval),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  // per-detector bin counts
  geh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CNT_DEPTH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // config: always ready, bins in use clamped to [1, MAX_BINS] on write
  assign cfg_ready_o = 1'b1;
  assign cfg_nb      = cfg_data_i[NB_CFG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_end_q   <= '0;
      nb_q        <= BIN_W'(MAX_BINS);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIN_START: win_start_q <= cfg_data_i[FTIME_W-1:0];
        CFG_WIN_END:   win_end_q   <= cfg_data_i[FTIME_W-1:0];
        CFG_NUM_BINS: begin
          if (cfg_nb == '0) begin
            nb_q <= BIN_W'(1);
          end else if (32'(cfg_nb) > MAX_BINS) begin
            nb_q <= BIN_W'(MAX_BINS);
          end else begin
            nb_q <= BIN_W'(cfg_nb);
          end
        end
        default: ;
      endcase
    end
  end

  // state register and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      fa_q      <= 1'b0;
      frames_q  <= '0;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fa_q      <= fa_d;
      frames_q  <= frames_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    det_q      <= det_d;
    tof_q      <= tof_d;
    ftime_q    <= ftime_d;
    rd_ok_q    <= rd_ok_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    ge_start_q <= ge_start_d;
    res_kind_q <= res_kind_d;
    res_q      <= res_d;
    if (out_load) begin
      m_kind_q <= res_kind_q;
      m_word_q <= res_q;
    end
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    fa_d          = fa_q;
    frames_d      = frames_q;
    clr_d         = clr_q;
    ge_start_d    = ge_start_q;
    det_d         = det_q;
    tof_d         = tof_q;
    ftime_d       = ftime_q;
    rd_ok_d       = rd_ok_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    res_kind_d    = res_kind_q;
    res_d         = res_q;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    edge_we       = 1'b0;
    edge_raddr    = '0;
    cnt_we        = 1'b0;
    cnt_waddr     = cnt_addr(det_q, lo_q);
    cnt_wdata     = '0;
    cnt_raddr     = cnt_addr(det_q, lo_q);
    cmp_sel       = CMP_EDGE;

    unique case (state_q)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        clr_d     = clr_q + CNT_AW'(1);
        if (clr_q == CNT_AW'(CNT_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        s_axis_tready = 1'b1;
        // edge 0 and the addressed count are fetched on the accept edge
        edge_raddr = '0;
        cnt_raddr  = cnt_addr(in_det, BIN_W'(in_bidx));
        if (s_axis_tvalid) begin
          det_d   = in_det;
          tof_d   = in_tof;
          ftime_d = in_ftime;
          rd_ok_d = (32'(in_det) < NUM_DETECTORS) && (32'(in_bidx) < 32'(nb_q));
          unique case (in_kind)
            KIND_FRAME: state_d = S_FR_LO;
            KIND_EVENT: begin
              if (fa_q && (in_det != '0) && (32'(in_det) < NUM_DETECTORS)) begin
                state_d = S_EDGE_LO;
              end
            end
            KIND_EDGE: edge_we = (32'(in_eidx) <= MAX_BINS);
            KIND_READ: state_d = S_READ;
            default: ;
          endcase
        end
      end

      S_FR_LO: begin
        cmp_sel    = CMP_WIN_START;
        ge_start_d = !cmp_lt;
        state_d    = S_FR_HI;
      end

      S_FR_HI: begin
        cmp_sel = CMP_WIN_END;
        fa_d    = ge_start_q && cmp_lt;
        if (fa_d && (frames_q != '1)) begin
          frames_d = frames_q + CNT_W'(1);
        end
        res_kind_d   = RES_FRAME;
        res_d.fiw    = fa_d;
        res_d.frames = frames_d;
        res_d.count  = '0;
        state_d      = S_OUT;
      end

      // below edge 0: reject, else fetch the top edge
      S_EDGE_LO: begin
        if (cmp_lt) begin
          state_d = S_IDLE;
        end else begin
          edge_raddr = EDGE_AW'(nb_q);
          state_d    = S_EDGE_HI;
        end
      end

      S_EDGE_HI: begin
        if (!cmp_lt) begin
          state_d = S_IDLE;
        end else begin
          lo_d = '0;
          hi_d = nb_q;
          if (nb_q > BIN_W'(1)) begin
            edge_raddr = EDGE_AW'(sum_d[BIN_W:1]);
            state_d    = S_SEARCH;
          end else begin
            cnt_raddr = cnt_addr(det_q, lo_d);
            state_d   = S_CNT_WR;
          end
        end
      end

      // one halving step per cycle on edge[mid]
      S_SEARCH: begin
        if (cmp_lt) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q;
        end
        if (span_d > BIN_W'(1)) begin
          edge_raddr = EDGE_AW'(sum_d[BIN_W:1]);
        end else begin
          cnt_raddr = cnt_addr(det_q, lo_d);
          state_d   = S_CNT_WR;
        end
      end

      S_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = cnt_addr(det_q, lo_q);
        cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + CNT_W'(1);
        state_d   = S_IDLE;
      end

      S_READ: begin
        res_kind_d   = RES_COUNT;
        res_d.fiw    = fa_q;
        res_d.frames = frames_q;
        res_d.count  = rd_ok_q ? cnt_rdata : '0;
        state_d      = S_OUT;
      end

      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = OUT_DATA_W'(m_word_q);

endmodule

// ----- rtl/geh_checker.sv -----
module geh_checker import geh_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [KIND_W-1:0]     s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [RES_KIND_W-1:0] m_axis_tuser
);

  logic is_frame_rpt;

  assign is_frame_rpt = m_axis_tvalid && (m_axis_tuser == RES_FRAME);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed under stall");

  // frame reports never carry a bin count
  a_frame_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_frame_rpt |-> (m_axis_tdata[COUNT_LSB +: CNT_W] == '0))
    else $error("frame report with nonzero bin count");

  // an accepted frame leaves the saturating frame count above zero
  a_frame_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_frame_rpt && m_axis_tdata[FIW_LSB] |-> (m_axis_tdata[FRAMES_LSB +: CNT_W] != '0))
    else $error("accepted frame reported with zero frame count");

  // headers and count reads keep the block busy on the following cycle
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
      ((s_axis_tuser == KIND_FRAME) || (s_axis_tuser == KIND_READ)) |=> !s_axis_tready)
    else $error("ready while a result is being built");

endmodule

bind gated_event_histogrammer geh_checker u_geh_checker (.*);
